// ===== rtl/rgb_to_hsv_converter_top_assert.svh =====
// assertion macros shared by the rgb to hsv converter rtl
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef RGB_TO_HSV_CONVERTER_TOP_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_TOP_ASSERT_SVH

// condition in a cycle implies a consequence in the same cycle
`define RHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rhc assertion failed");

// condition in a cycle implies a consequence in the next cycle
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rhc assertion failed");

`endif

// ===== rtl/rhc_pkg.sv =====
// shared types, constants and width helpers of the rgb to hsv converter
// no dependencies
package rhc_pkg;

  // fixed field widths
  localparam int ChanW = 8;
  localparam int HueW  = 15;
  localparam int SatW  = 13;

  // default fraction sizes
  localparam int HueFracBitsDef = 6;
  localparam int SatFracBitsDef = 12;

  // quotient bits resolved per divider stage
  localparam int DivBitsPerStage = 4;

  // hue geometry
  localparam int HueSpanDeg   = 360;
  localparam int HueSectorDeg = 60;
  localparam int SectorWrap   = HueSpanDeg / HueSectorDeg;

  // width of sector_base * delta + diff, at most six times the channel max
  localparam int BaseW = ChanW + 3;

  // hue sector picked by the largest channel; red with negative diff wraps by 360
  typedef enum logic [1:0] {
    SecRed     = 2'd0,
    SecGreen   = 2'd1,
    SecBlue    = 2'd2,
    SecRedWrap = 2'd3
  } sector_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  saturation;
    logic [ChanW-1:0] brightness;
    logic             hue_undefined;
  } hsv_t;

  // per-item flags that ride along the divider
  typedef struct packed {
    logic [ChanW-1:0] brightness;
    logic             hue_undef;
    logic             black;
  } side_t;

  // sector offset in units of 60 degrees: 0, 2, 4 or 6
  function automatic logic [2:0] sector_base(sector_e sec);
    return {sec, 1'b0};
  endfunction

  // bits of the hue dividend, which stays below six sectors of full delta
  function automatic int hue_num_w(int hfb);
    return $clog2(SectorWrap * ((2 ** ChanW) - 1) * HueSectorDeg * (2 ** hfb));
  endfunction

  // common dividend width of both divider lanes
  function automatic int div_w(int hfb, int sfb);
    int hw;
    int sw;
    hw = hue_num_w(hfb);
    sw = ChanW + sfb;
    return (hw > sw) ? hw : sw;
  endfunction

endpackage

// ===== rtl/rgb_to_hsv_converter_top.sv =====
// top level of the rgb to hsv converter: prep stages, divider, output stage
// depends on rhc_pkg, rhc_prep, rhc_div, rhc_out and the assertion header
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (red green blue)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (hue sat val undef)
//
// one pixel per clock is taken and given while out_stall_i is low; every stage
// advances when it is empty or its successor moves, so bubbles close up under a
// stall and nothing is lost. the divider resolves 4 quotient bits per stage; at the
// default sizes DivW is 23.
// reset clears only the valid bits; no state survives an item.
`include "rgb_to_hsv_converter_top_assert.svh"

module rgb_to_hsv_converter_top #(
  parameter int HueFracBits = rhc_pkg::HueFracBitsDef,
  parameter int SatFracBits = rhc_pkg::SatFracBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rhc_pkg::pixel_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rhc_pkg::hsv_t   out_data_o
);

  localparam int DivW = rhc_pkg::div_w(HueFracBits, SatFracBits);

  logic                           prep_rdy, prep_vld;
  logic [1:0][DivW-1:0]           prep_num;
  logic [1:0][rhc_pkg::ChanW-1:0] prep_den;
  rhc_pkg::side_t                 prep_side;

  logic                           div_rdy, div_vld;
  logic [1:0][DivW-1:0]           div_quo;
  rhc_pkg::side_t                 div_side;

  logic                           out_rdy, fin_rdy;

  assign in_stall_o = !prep_rdy;
  assign out_rdy    = !out_stall_i;

  // max, min, sector and dividends
  rhc_prep #(
    .HueFracBits (HueFracBits),
    .SatFracBits (SatFracBits),
    .DivW        (DivW)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (in_valid_i),
    .in_rdy_o   (prep_rdy),
    .in_data_i  (in_data_i),
    .out_vld_o  (prep_vld),
    .out_rdy_i  (div_rdy),
    .out_num_o  (prep_num),
    .out_den_o  (prep_den),
    .out_side_o (prep_side)
  );

  // hue and saturation quotients
  rhc_div #(
    .DivW (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (prep_vld),
    .in_rdy_o   (div_rdy),
    .in_num_i   (prep_num),
    .in_den_i   (prep_den),
    .in_side_i  (prep_side),
    .out_vld_o  (div_vld),
    .out_rdy_i  (fin_rdy),
    .out_quo_o  (div_quo),
    .out_side_o (div_side)
  );

  // clamping and output register
  rhc_out #(
    .DivW (DivW)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (div_vld),
    .in_rdy_o   (fin_rdy),
    .in_quo_i   (div_quo),
    .in_side_i  (div_side),
    .out_vld_o  (out_valid_o),
    .out_rdy_i  (out_rdy),
    .out_data_o (out_data_o)
  );

  // checks
  `RHC_ASSERT_NOW(a_undef_hue_zero, out_valid_o && out_data_o.hue_undefined, out_data_o.hue == '0)
  `RHC_ASSERT_NOW(a_black_gray, out_valid_o && (out_data_o.brightness == '0), out_data_o.saturation == '0 && out_data_o.hue_undefined)
  `RHC_ASSERT_NOW(a_color_has_sat, out_valid_o && !out_data_o.hue_undefined, out_data_o.saturation != '0)
  `RHC_ASSERT_NOW(a_free_flow, !out_stall_i, !in_stall_o)
  `RHC_ASSERT_NEXT(a_prep_hold, prep_vld && !div_rdy, prep_vld)

endmodule

// ===== rtl/rhc_prep.sv =====
// front stages: max, min, delta and sector, then both dividends and divisors
// depends on rhc_pkg
module rhc_prep #(
  parameter int HueFracBits = rhc_pkg::HueFracBitsDef,
  parameter int SatFracBits = rhc_pkg::SatFracBitsDef,
  parameter int DivW        = rhc_pkg::div_w(HueFracBits, SatFracBits)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_vld_i,
  output logic                             in_rdy_o,
  input  rhc_pkg::pixel_t                  in_data_i,
  output logic                             out_vld_o,
  input  logic                             out_rdy_i,
  output logic [1:0][DivW-1:0]             out_num_o,
  output logic [1:0][rhc_pkg::ChanW-1:0]   out_den_o,
  output rhc_pkg::side_t                   out_side_o
);

  localparam int CW = rhc_pkg::ChanW;
  localparam int BW = rhc_pkg::BaseW;

  // stage a: extremes, delta and sector
  logic [CW-1:0]        hi;
  logic [CW-1:0]        lo;
  logic signed [CW:0]   diff;
  rhc_pkg::sector_e     sec;

  always_comb begin
    hi = in_data_i.red;
    if (in_data_i.green > hi) hi = in_data_i.green;
    if (in_data_i.blue > hi) hi = in_data_i.blue;
    lo = in_data_i.red;
    if (in_data_i.green < lo) lo = in_data_i.green;
    if (in_data_i.blue < lo) lo = in_data_i.blue;
    if (in_data_i.red == hi) begin
      diff = $signed({1'b0, in_data_i.green}) - $signed({1'b0, in_data_i.blue});
      sec  = (diff < 0) ? rhc_pkg::SecRedWrap : rhc_pkg::SecRed;
    end else if (in_data_i.green == hi) begin
      diff = $signed({1'b0, in_data_i.blue}) - $signed({1'b0, in_data_i.red});
      sec  = rhc_pkg::SecGreen;
    end else begin
      diff = $signed({1'b0, in_data_i.red}) - $signed({1'b0, in_data_i.green});
      sec  = rhc_pkg::SecBlue;
    end
  end

  logic               vld_a_q, vld_b_q;
  logic               adv_a, adv_b;
  logic [CW-1:0]      hi_a_q, delta_a_q;
  logic signed [CW:0] diff_a_q;
  rhc_pkg::sector_e   sec_a_q;

  // stage advance chain
  assign adv_b    = !vld_b_q || out_rdy_i;
  assign adv_a    = !vld_a_q || adv_b;
  assign in_rdy_o = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (adv_a) begin
      vld_a_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      hi_a_q    <= hi;
      delta_a_q <= hi - lo;
      diff_a_q  <= diff;
      sec_a_q   <= sec;
    end
  end

  // stage b: hue dividend (base*delta + diff) * 60 * 2^frac, sat dividend delta * 2^frac
  logic [BW-1:0]        base_mul;
  logic signed [BW:0]   sum_s;
  logic [DivW-1:0]      hue_num;
  logic [DivW-1:0]      sat_num;

  always_comb begin
    base_mul = BW'(rhc_pkg::sector_base(sec_a_q)) * BW'(delta_a_q);
    sum_s    = $signed({1'b0, base_mul}) + (BW + 1)'(diff_a_q);
    hue_num  = (DivW'(sum_s[BW-1:0]) * DivW'(rhc_pkg::HueSectorDeg)) << HueFracBits;
    sat_num  = DivW'(delta_a_q) << SatFracBits;
  end

  logic [1:0][DivW-1:0] num_b_q;
  logic [1:0][CW-1:0]   den_b_q;
  rhc_pkg::side_t       side_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (adv_b) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      num_b_q[0]          <= hue_num;
      num_b_q[1]          <= sat_num;
      den_b_q[0]          <= delta_a_q;
      den_b_q[1]          <= hi_a_q;
      side_b_q.brightness <= hi_a_q;
      side_b_q.hue_undef  <= (delta_a_q == '0);
      side_b_q.black      <= (hi_a_q == '0);
    end
  end

  assign out_vld_o  = vld_b_q;
  assign out_num_o  = num_b_q;
  assign out_den_o  = den_b_q;
  assign out_side_o = side_b_q;

endmodule

// ===== rtl/rhc_div.sv =====
// pipelined restoring divider, two lanes in lockstep (hue and saturation)
// depends on rhc_pkg
module rhc_div #(
  parameter int DivW = rhc_pkg::div_w(rhc_pkg::HueFracBitsDef, rhc_pkg::SatFracBitsDef)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_vld_i,
  output logic                           in_rdy_o,
  input  logic [1:0][DivW-1:0]           in_num_i,
  input  logic [1:0][rhc_pkg::ChanW-1:0] in_den_i,
  input  rhc_pkg::side_t                 in_side_i,
  output logic                           out_vld_o,
  input  logic                           out_rdy_i,
  output logic [1:0][DivW-1:0]           out_quo_o,
  output rhc_pkg::side_t                 out_side_o
);

  localparam int CW        = rhc_pkg::ChanW;
  localparam int Bps       = rhc_pkg::DivBitsPerStage;
  localparam int NumStages = (DivW + Bps - 1) / Bps;
  localparam int PW        = NumStages * Bps;

  // Bps quotient bits: shift dividend into remainder, subtract when it fits
  function automatic logic [CW+PW-1:0] div_step(logic [CW-1:0] rem, logic [PW-1:0] work,
                                                logic [CW-1:0] den);
    logic [CW:0]   trial;
    logic [CW-1:0] r;
    logic [PW-1:0] w;
    r = rem;
    w = work;
    for (int i = 0; i < Bps; i++) begin
      trial = {r, w[PW-1]};
      w     = {w[PW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
        w[0]  = 1'b1;
      end
      r = trial[CW-1:0];
    end
    return {r, w};
  endfunction

  logic                 vld_q    [NumStages];
  logic                 adv      [NumStages];
  logic [1:0][PW-1:0]   work_q   [NumStages];
  logic [1:0][CW-1:0]   rem_q    [NumStages];
  logic [1:0][CW-1:0]   den_q    [NumStages];
  rhc_pkg::side_t       side_q   [NumStages];

  logic                 vld_in   [NumStages];
  logic [1:0][PW-1:0]   work_in  [NumStages];
  logic [1:0][CW-1:0]   rem_in   [NumStages];
  logic [1:0][CW-1:0]   den_in   [NumStages];
  rhc_pkg::side_t       side_in  [NumStages];
  logic [1:0][CW+PW-1:0] step    [NumStages];

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    // stage inputs
    if (s == 0) begin : g_first
      assign vld_in[s]     = in_vld_i;
      assign work_in[s][0] = PW'(in_num_i[0]);
      assign work_in[s][1] = PW'(in_num_i[1]);
      assign rem_in[s]     = '0;
      assign den_in[s]     = in_den_i;
      assign side_in[s]    = in_side_i;
    end else begin : g_next
      assign vld_in[s]  = vld_q[s-1];
      assign work_in[s] = work_q[s-1];
      assign rem_in[s]  = rem_q[s-1];
      assign den_in[s]  = den_q[s-1];
      assign side_in[s] = side_q[s-1];
    end

    // advance when empty or when the next stage moves
    if (s == NumStages - 1) begin : g_last
      assign adv[s] = !vld_q[s] || out_rdy_i;
    end else begin : g_mid
      assign adv[s] = !vld_q[s] || adv[s+1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      assign step[s][l] = div_step(rem_in[s][l], work_in[s][l], den_in[s][l]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv[s]) begin
        vld_q[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        work_q[s][0] <= step[s][0][PW-1:0];
        work_q[s][1] <= step[s][1][PW-1:0];
        rem_q[s][0]  <= step[s][0][CW+PW-1:PW];
        rem_q[s][1]  <= step[s][1][CW+PW-1:PW];
        den_q[s]     <= den_in[s];
        side_q[s]    <= side_in[s];
      end
    end
  end

  assign in_rdy_o     = adv[0];
  assign out_vld_o    = vld_q[NumStages-1];
  assign out_quo_o[0] = work_q[NumStages-1][0][DivW-1:0];
  assign out_quo_o[1] = work_q[NumStages-1][1][DivW-1:0];
  assign out_side_o   = side_q[NumStages-1];

endmodule

// ===== rtl/rhc_out.sv =====
// output stage: clamps quotients to their fields, forces gray and black cases
// depends on rhc_pkg
module rhc_out #(
  parameter int DivW = rhc_pkg::div_w(rhc_pkg::HueFracBitsDef, rhc_pkg::SatFracBitsDef)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_vld_i,
  output logic                 in_rdy_o,
  input  logic [1:0][DivW-1:0] in_quo_i,
  input  rhc_pkg::side_t       in_side_i,
  output logic                 out_vld_o,
  input  logic                 out_rdy_i,
  output rhc_pkg::hsv_t        out_data_o
);

  localparam int HW = rhc_pkg::HueW;
  localparam int SW = rhc_pkg::SatW;

  rhc_pkg::hsv_t res;

  // saturate oversized quotients, zero the undefined cases
  always_comb begin
    if (in_side_i.hue_undef) begin
      res.hue = '0;
    end else if ((in_quo_i[0] >> HW) != '0) begin
      res.hue = '1;
    end else begin
      res.hue = in_quo_i[0][HW-1:0];
    end
    if (in_side_i.black) begin
      res.saturation = '0;
    end else if ((in_quo_i[1] >> SW) != '0) begin
      res.saturation = '1;
    end else begin
      res.saturation = in_quo_i[1][SW-1:0];
    end
    res.brightness    = in_side_i.brightness;
    res.hue_undefined = in_side_i.hue_undef;
  end

  logic          vld_q;
  logic          adv;
  rhc_pkg::hsv_t data_q;

  assign adv      = !vld_q || out_rdy_i;
  assign in_rdy_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      data_q <= res;
    end
  end

  assign out_vld_o  = vld_q;
  assign out_data_o = data_q;

endmodule
